// ===== rtl/rpd_pkg.sv =====
package rpd_pkg;

    localparam logic [7:0] MAGIC0   = 8'hB0;
    localparam logic [7:0] MAGIC1   = 8'h0B;
    localparam logic [7:0] CODE_16  = 8'd254;
    localparam logic [31:0] HDR_LEN = 32'd8;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_OK     = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    typedef struct packed {
        logic       hunt_start;
        logic       len_shift;
        logic       id_load;
        logic       cnt_load;
        logic       pos_inc;
        logic       code_start;
        logic       code_acc;
        logic       code_finish;
        logic       scan_zero;
        logic       scan_body;
        logic       scan_next;
        logic       scan_read;
        logic       region_take;
        logic       body_dec;
        logic       body_clear;
        logic       hold_data;
        logic       push;
        logic       push_hold;
        logic [1:0] push_kind;
        logic       push_last;
    } cmd_t;

    typedef struct packed {
        logic magic0;
        logic magic1;
        logic lt254;
        logic len_done;
        logic len_bad;
        logic cnt_zero;
        logic cnt_over;
        logic left_zero;
        logic left_one;
        logic codes_done;
        logic check_ok;
        logic sum_zero;
        logic remain_le1;
        logic scan_end;
        logic rdata_nz;
    } sts_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] region;
        logic       rend;
        logic [7:0] id;
        logic [7:0] total;
        logic       last;
    } res_t;

endpackage

// ===== rtl/rpd_ram.sv =====
module rpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/rpd_outq.sv =====
module rpd_outq
    import rpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_res,
    output logic full,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    res_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign full      = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_res   = q_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/rpd_datapath.sv =====
module rpd_datapath
    import rpd_pkg::*;
#(
    parameter int MAX_REGIONS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  in_byte,
    input  logic        cfg_we,
    input  logic [31:0] cfg_value,
    input  cmd_t        cmd,
    output sts_t        sts,
    output res_t        res
);

    localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam logic [8:0] MAX_R = MAX_REGIONS[8:0];

    logic [31:0] max_len_reg;
    logic [31:0] len_reg;
    logic [31:0] pos_reg;
    logic [7:0]  id_reg;
    logic [7:0]  cnt_reg;
    logic [7:0]  hidx_reg;
    logic [31:0] acc_reg;
    logic [2:0]  left_reg;
    logic [32:0] sum_reg;
    logic [8:0]  scan_reg;
    logic [7:0]  body_reg;
    logic [31:0] remain_reg;
    logic [7:0]  hold_reg;

    logic [31:0] len_next;
    logic [31:0] code_len;
    logic [33:0] sum_add;
    logic [32:0] sum_next;
    logic [32:0] diff;
    logic [31:0] rdata;

    assign len_next = {len_reg[23:0], in_byte};
    assign code_len = (left_reg == 3'd0) ? {24'd0, in_byte} : {acc_reg[23:0], in_byte};
    assign sum_add  = {1'b0, sum_reg} + {2'b0, code_len};
    // saturate so an overflowed sum can never match
    assign sum_next = sum_add[33] ? {33{1'b1}} : sum_add[32:0];
    assign diff     = {1'b0, len_reg} - {1'b0, pos_reg};

    rpd_ram #(.WIDTH(32), .DEPTH(MAX_REGIONS)) u_ram (
        .clk   (clk),
        .we    (cmd.code_finish),
        .waddr (hidx_reg[AW-1:0]),
        .wdata (code_len),
        .re    (cmd.scan_read),
        .raddr (scan_reg[AW-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        sts.magic0     = (in_byte == MAGIC0);
        sts.magic1     = (in_byte == MAGIC1);
        sts.lt254      = (in_byte < CODE_16);
        sts.len_done   = (pos_reg == 32'd5);
        sts.len_bad    = (len_next < HDR_LEN) || (len_next > max_len_reg);
        sts.cnt_zero   = (in_byte == 8'd0);
        sts.cnt_over   = ({1'b0, in_byte} > MAX_R);
        sts.left_zero  = (left_reg == 3'd0);
        sts.left_one   = (left_reg == 3'd1);
        sts.codes_done = (({1'b0, hidx_reg} + 9'd1) >= {1'b0, cnt_reg});
        sts.check_ok   = (pos_reg <= len_reg) && (sum_reg == diff);
        sts.sum_zero   = (sum_reg == 33'd0);
        sts.remain_le1 = (remain_reg <= 32'd1);
        sts.scan_end   = (scan_reg >= {1'b0, cnt_reg});
        sts.rdata_nz   = (rdata != 32'd0);
    end

    always_comb
    begin
        res.kind  = cmd.push_kind;
        res.last  = cmd.push_last;
        res.id    = id_reg;
        res.total = cmd.cnt_load ? in_byte : cnt_reg;
        if (cmd.push_kind == KIND_DATA)
        begin
            res.data   = cmd.push_hold ? hold_reg : in_byte;
            res.region = body_reg;
            res.rend   = cmd.push_hold | sts.remain_le1;
        end
        else
        begin
            res.data   = 8'd0;
            res.region = 8'd0;
            res.rend   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hold_data)
        begin
            hold_reg <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= 32'd65536;
            len_reg     <= 32'd0;
            pos_reg     <= 32'd0;
            id_reg      <= 8'd0;
            cnt_reg     <= 8'd0;
            hidx_reg    <= 8'd0;
            acc_reg     <= 32'd0;
            left_reg    <= 3'd0;
            sum_reg     <= 33'd0;
            scan_reg    <= 9'd0;
            body_reg    <= 8'd0;
            remain_reg  <= 32'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_len_reg <= cfg_value;
            end
            if (cmd.hunt_start)
            begin
                pos_reg <= 32'd2;
                len_reg <= 32'd0;
                id_reg  <= 8'd0;
                cnt_reg <= 8'd0;
            end
            if (cmd.pos_inc)
            begin
                pos_reg <= pos_reg + 32'd1;
            end
            if (cmd.len_shift)
            begin
                len_reg <= len_next;
            end
            if (cmd.id_load)
            begin
                id_reg <= in_byte;
            end
            if (cmd.cnt_load)
            begin
                cnt_reg  <= in_byte;
                hidx_reg <= 8'd0;
                left_reg <= 3'd0;
                acc_reg  <= 32'd0;
                sum_reg  <= 33'd0;
            end
            if (cmd.code_start)
            begin
                left_reg <= (in_byte == CODE_16) ? 3'd2 : 3'd4;
                acc_reg  <= 32'd0;
            end
            if (cmd.code_acc)
            begin
                acc_reg  <= {acc_reg[23:0], in_byte};
                left_reg <= left_reg - 3'd1;
            end
            if (cmd.code_finish)
            begin
                sum_reg  <= sum_next;
                hidx_reg <= hidx_reg + 8'd1;
            end
            if (cmd.scan_zero)
            begin
                scan_reg <= 9'd0;
            end
            if (cmd.scan_body)
            begin
                scan_reg <= {1'b0, body_reg} + 9'd1;
            end
            if (cmd.scan_next)
            begin
                scan_reg <= scan_reg + 9'd1;
            end
            if (cmd.body_dec && (remain_reg != 32'd0))
            begin
                remain_reg <= remain_reg - 32'd1;
            end
            if (cmd.region_take)
            begin
                body_reg   <= scan_reg[7:0];
                remain_reg <= rdata;
            end
            if (cmd.body_clear)
            begin
                body_reg <= 8'd0;
            end
        end
    end

endmodule

// ===== rtl/rpd_ctrl.sv =====
module rpd_ctrl
    import rpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic q_full,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] ST_HUNT0   = 4'd0;
    localparam logic [3:0] ST_HUNT1   = 4'd1;
    localparam logic [3:0] ST_LEN     = 4'd2;
    localparam logic [3:0] ST_ID      = 4'd3;
    localparam logic [3:0] ST_COUNT   = 4'd4;
    localparam logic [3:0] ST_CODE    = 4'd5;
    localparam logic [3:0] ST_BODY    = 4'd6;
    localparam logic [3:0] ST_ERR2    = 4'd7;
    localparam logic [3:0] ST_CHECK   = 4'd8;
    localparam logic [3:0] ST_SCAN    = 4'd9;
    localparam logic [3:0] ST_SCANCHK = 4'd10;
    localparam logic [3:0] ST_OKP     = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       pending_reg;
    logic       pending_next;
    logic       acc;

    assign in_ready = (state_reg <= ST_BODY) && !q_full;
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        pending_next = pending_reg;
        case (state_reg)
            ST_HUNT0:
            begin
                if (acc && sts.magic0)
                begin
                    state_next = ST_HUNT1;
                end
            end
            ST_HUNT1:
            begin
                if (acc)
                begin
                    if (sts.magic1)
                    begin
                        cmd.hunt_start = 1'b1;
                        state_next     = ST_LEN;
                    end
                    else if (!sts.magic0)
                    begin
                        state_next = ST_HUNT0;
                    end
                end
            end
            ST_LEN:
            begin
                if (acc)
                begin
                    cmd.len_shift = 1'b1;
                    cmd.pos_inc   = 1'b1;
                    if (sts.len_done)
                    begin
                        if (sts.len_bad)
                        begin
                            cmd.push      = 1'b1;
                            cmd.push_kind = KIND_ERROR;
                            cmd.push_last = 1'b1;
                            state_next    = ST_HUNT0;
                        end
                        else
                        begin
                            state_next = ST_ID;
                        end
                    end
                end
            end
            ST_ID:
            begin
                if (acc)
                begin
                    cmd.id_load = 1'b1;
                    cmd.pos_inc = 1'b1;
                    state_next  = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (acc)
                begin
                    cmd.cnt_load  = 1'b1;
                    cmd.pos_inc   = 1'b1;
                    cmd.push      = 1'b1;
                    cmd.push_kind = KIND_HEADER;
                    if (sts.cnt_over)
                    begin
                        state_next = ST_ERR2;
                    end
                    else if (sts.cnt_zero)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        cmd.push_last = 1'b1;
                        state_next    = ST_CODE;
                    end
                end
            end
            ST_CODE:
            begin
                if (acc)
                begin
                    cmd.pos_inc = 1'b1;
                    if (sts.left_zero)
                    begin
                        if (sts.lt254)
                        begin
                            cmd.code_finish = 1'b1;
                        end
                        else
                        begin
                            cmd.code_start = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.code_acc = 1'b1;
                        if (sts.left_one)
                        begin
                            cmd.code_finish = 1'b1;
                        end
                    end
                    if (cmd.code_finish && sts.codes_done)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_BODY:
            begin
                if (acc)
                begin
                    cmd.body_dec = 1'b1;
                    if (sts.remain_le1)
                    begin
                        // last byte of region: hold it until the next region is known
                        cmd.hold_data = 1'b1;
                        cmd.scan_body = 1'b1;
                        pending_next  = 1'b1;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        cmd.push      = 1'b1;
                        cmd.push_kind = KIND_DATA;
                        cmd.push_last = 1'b1;
                    end
                end
            end
            ST_ERR2:
            begin
                if (!q_full)
                begin
                    cmd.push      = 1'b1;
                    cmd.push_kind = KIND_ERROR;
                    cmd.push_last = 1'b1;
                    state_next    = ST_HUNT0;
                end
            end
            ST_CHECK:
            begin
                if (!q_full)
                begin
                    if (sts.check_ok && !sts.sum_zero)
                    begin
                        cmd.scan_zero = 1'b1;
                        pending_next  = 1'b0;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        cmd.push      = 1'b1;
                        cmd.push_kind = sts.check_ok ? KIND_OK : KIND_ERROR;
                        cmd.push_last = 1'b1;
                        state_next    = ST_HUNT0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_end)
                begin
                    if (!q_full)
                    begin
                        cmd.push       = 1'b1;
                        cmd.push_hold  = 1'b1;
                        cmd.push_kind  = KIND_DATA;
                        cmd.body_clear = 1'b1;
                        state_next     = ST_OKP;
                    end
                end
                else
                begin
                    cmd.scan_read = 1'b1;
                    state_next    = ST_SCANCHK;
                end
            end
            ST_SCANCHK:
            begin
                if (sts.rdata_nz)
                begin
                    if (!pending_reg || !q_full)
                    begin
                        cmd.push        = pending_reg;
                        cmd.push_hold   = 1'b1;
                        cmd.push_kind   = KIND_DATA;
                        cmd.push_last   = 1'b1;
                        cmd.region_take = 1'b1;
                        pending_next    = 1'b0;
                        state_next      = ST_BODY;
                    end
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_OKP:
            begin
                if (!q_full)
                begin
                    cmd.push      = 1'b1;
                    cmd.push_kind = KIND_OK;
                    cmd.push_last = 1'b1;
                    pending_next  = 1'b0;
                    state_next    = ST_HUNT0;
                end
            end
            default:
            begin
                state_next = ST_HUNT0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_HUNT0;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// ===== rtl/region_packet_deframer.sv =====
// region packet deframer
// s_* carries the input byte stream, one byte per word; m_* carries results:
// m_tuser is the result kind (data, header seen, packet ok, error), m_tdata
// the data byte, region index, region end flag, packet id and region count,
// m_tlast marks the last result caused by one input byte.
// cfg_* writes the largest accepted total packet length (reset 65536);
// write it only while the block is idle.
// header, code and body bytes are taken back to back while the queue has room,
// and each result is registered in the output queue; s_tready stays low while
// the block works alone: in the check after the last length code, or for the
// second result of a count byte; then in a scan and a check state per region
// while the region length table (a ram with a separate write port and
// registered read) is scanned for the next nonempty region, after a good check
// and after the last byte of each region; when none is left, the held data word and packet ok are sent.
// a two-word output queue lets the next byte enter while a result waits;
// when the receiver stalls the queue fills and s_tready drops.
// reset returns the parser to hunting for the magic bytes and empties the
// queue; the length table needs no clearing.
module region_packet_deframer
    import rpd_pkg::*;
#(
    parameter int MAX_REGIONS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // data_byte, region_index, region_end, packet_id,
                                   // region_total, zero pad
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;
    res_t push_res;
    res_t out_res;
    logic q_full;

    assign cfg_ready = 1'b1;

    rpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .q_full   (q_full),
        .sts      (sts),
        .cmd      (cmd)
    );

    rpd_datapath #(.MAX_REGIONS(MAX_REGIONS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_value (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .res       (push_res)
    );

    rpd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd.push),
        .push_res  (push_res),
        .full      (q_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;
    assign m_tdata = {7'd0, out_res.total, out_res.id, out_res.rend,
                      out_res.region, out_res.data};

endmodule

// ===== rtl/rpd_checker.sv =====
module rpd_checker
    import rpd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_DATA) |-> (m_tdata[16:0] == 17'd0))
        else $error("data fields set on a non-data result");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == KIND_OK) || (m_tuser == KIND_ERROR)) |-> m_tlast)
        else $error("packet end without last");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[39:33] == 7'd0))
        else $error("pad bits set");

endmodule

bind region_packet_deframer rpd_checker u_rpd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
